FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file pfq_checker.sv.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pfq_pkg.sv
`default_nettype none
package pfq_pkg;

  // Default sizing
  localparam int LEVELS_DEF      = 5;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  // Fixed field widths on the stream ports
  localparam int MODE_W     = 2;
  localparam int PRIO_W     = 3;
  localparam int ITEM_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [1:0]        status_t;

  // Operation codes
  localparam mode_t MODE_ENQ  = 2'd0;
  localparam mode_t MODE_DEQ  = 2'd1;
  localparam mode_t MODE_PEEK = 2'd2;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_BADPRIO = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage
`default_nettype wire

FILE: rtl/core/five_level_priority_fifo_queue.sv
// Strict-priority queue: LEVELS FIFOs of item identifiers sharing one slot memory,
// level 1 the most urgent. Each input beat carries an operation in in_tuser
// (enqueue, dequeue, peek; the unused code does nothing and returns ok) and gives
// exactly one result beat with a status in out_tuser, the served identifier and
// level, and a flag that is set when every level is empty after the operation.
// Enqueue, and any dequeue or peek on an empty queue, give their result in the
// cycle after the input beat; a dequeue or peek that serves an item passes first
// through the read state, as the head entry comes out of the slot memory's
// registered read port. One operation is in flight at a time; the next input
// beat is taken in the cycle the result register is emptied. Head and count of
// each level live in flip-flops, so no clearing pass is needed after reset.
`default_nettype none
module five_level_priority_fifo_queue #(
  parameter int LEVELS      = pfq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = pfq_pkg::LEVEL_DEPTH_DEF,
  parameter int ID_BITS     = pfq_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [2:0] priority_req, [18:3] item_id, [23:19] zero
  input  wire logic [pfq_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  wire logic [pfq_pkg::MODE_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] out_item_id, [18:16] out_priority, [19] now_empty, [23:20] zero
  output logic      [pfq_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic      [1:0]                     out_tuser
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int HD_W   = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  localparam logic [4:0]      LEVELS_V = 5'(LEVELS);
  localparam logic [CNT_W-1:0] FULL_V  = CNT_W'(LEVEL_DEPTH);
  localparam logic [HD_W:0]    DEPTH_V = (HD_W+1)'(LEVEL_DEPTH);
  localparam logic [HD_W-1:0]  LAST_V  = HD_W'(LEVEL_DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Control state
  logic                 state_r, state_nxt;
  logic [HD_W-1:0]      head_r  [LEVELS];
  logic [HD_W-1:0]      head_nxt[LEVELS];
  logic [CNT_W-1:0]     cnt_r   [LEVELS];
  logic [CNT_W-1:0]     cnt_nxt [LEVELS];
  logic                 out_valid_r, out_valid_nxt;

  // Result payload
  pfq_pkg::status_t     out_status_r, out_status_nxt;
  logic [15:0]          out_id_r, out_id_nxt;
  logic [2:0]           out_prio_r, out_prio_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [2:0]           pend_prio_r, pend_prio_nxt;
  logic                 pend_empty_r, pend_empty_nxt;

  // Decode and search
  logic                 in_fire;
  pfq_pkg::mode_t       mode;
  logic [2:0]           prio_req;
  logic [15:0]          item_id;
  logic                 prio_ok;
  logic [LVL_W+2:0]     prio_m1_ext;
  logic [LVL_W-1:0]     enq_lvl;
  logic [LVL_W-1:0]     sel_lvl;
  logic                 any_busy;
  logic [LVL_W+2:0]     sel_prio_ext;
  logic [HD_W:0]        tail_sum;
  logic [HD_W-1:0]      tail_pos;
  logic                 all_zero;

  // Memory ports
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [ID_BITS-1:0]   ram_wdata, ram_rdata;
  logic [ID_BITS+15:0]  id_wide;
  logic [ID_BITS+15:0]  rd_wide;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign mode      = in_tuser;
  assign prio_req  = in_tdata[2:0];
  assign item_id   = in_tdata[18:3];

  // Decode enqueue level
  assign prio_ok     = (prio_req != 3'd0) && ({2'b00, prio_req} <= LEVELS_V);
  assign prio_m1_ext = (LVL_W+3)'(prio_req - 3'd1);
  assign enq_lvl     = prio_m1_ext[LVL_W-1:0];

  // Find the most urgent level that holds an item
  always_comb begin
    sel_lvl  = '0;
    any_busy = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        sel_lvl  = LVL_W'(l);
        any_busy = 1'b1;
      end
    end
  end
  assign sel_prio_ext = (LVL_W+3)'(sel_lvl) + (LVL_W+3)'(1);

  // Tail slot of the enqueue level, wrapped once
  always_comb begin
    tail_sum = {1'b0, head_r[enq_lvl]} + {1'b0, cnt_r[enq_lvl][HD_W-1:0]};
    if (tail_sum >= DEPTH_V) begin
      tail_sum = tail_sum - DEPTH_V;
    end
    tail_pos = tail_sum[HD_W-1:0];
  end

  // Width-adjust the identifier into and out of the slot memory
  assign id_wide   = {{ID_BITS{1'b0}}, item_id};
  assign ram_wdata = id_wide[ID_BITS-1:0];
  assign rd_wide   = {16'd0, ram_rdata};

  assign ram_waddr = ADDR_W'(ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(tail_pos);
  assign ram_raddr = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(head_r[sel_lvl]);

  // Operation sequencing
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_empty_nxt  = out_empty_r;
    pend_prio_nxt  = pend_prio_r;
    pend_empty_nxt = pend_empty_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      head_nxt[l] = head_r[l];
      cnt_nxt[l]  = cnt_r[l];
    end

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      case (mode)
        pfq_pkg::MODE_ENQ: begin
          if (!prio_ok) begin
            out_status_nxt = pfq_pkg::ST_BADPRIO;
          end else if (cnt_r[enq_lvl] == FULL_V) begin
            out_status_nxt = pfq_pkg::ST_FULL;
          end else begin
            out_status_nxt   = pfq_pkg::ST_OK;
            ram_we           = 1'b1;
            cnt_nxt[enq_lvl] = cnt_r[enq_lvl] + CNT_W'(1);
          end
        end
        pfq_pkg::MODE_DEQ, pfq_pkg::MODE_PEEK: begin
          if (!any_busy) begin
            out_status_nxt = pfq_pkg::ST_EMPTY;
          end else begin
            out_status_nxt = pfq_pkg::ST_OK;
            ram_re         = 1'b1;
            state_nxt      = S_READ;
            pend_prio_nxt  = sel_prio_ext[2:0];
            if (mode == pfq_pkg::MODE_DEQ) begin
              cnt_nxt[sel_lvl]  = cnt_r[sel_lvl] - CNT_W'(1);
              head_nxt[sel_lvl] = (head_r[sel_lvl] == LAST_V) ? '0
                                                             : head_r[sel_lvl] + HD_W'(1);
            end
          end
        end
        default: begin
          out_status_nxt = pfq_pkg::ST_OK;
        end
      endcase

      all_zero = 1'b1;
      for (int l = 0; l < LEVELS; l++) begin
        if (cnt_nxt[l] != '0) begin
          all_zero = 1'b0;
        end
      end
      pend_empty_nxt = all_zero;

      // Results that need no memory data go out at once
      if (state_nxt == S_IDLE) begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_prio_nxt  = '0;
        out_empty_nxt = all_zero;
      end
    end else begin
      all_zero = 1'b0;
    end

    // Load the served item from the memory
    if (state_r == S_READ) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_id_nxt    = rd_wide[15:0];
      out_prio_nxt  = pend_prio_r;
      out_empty_nxt = pend_empty_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= head_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_empty_r  <= out_empty_nxt;
    pend_prio_r  <= pend_prio_nxt;
    pend_empty_r <= pend_empty_nxt;
  end

  pfq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_empty_r, out_prio_r, out_id_r};

endmodule
`default_nettype wire

FILE: rtl/core/pfq_ram.sv
`default_nettype none
module pfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pfq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [pfq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                     out_tuser
);

  logic [1:0] pend_r, pend_nxt;

  // Track beats accepted whose result is not yet taken
  always_comb begin
    pend_nxt = pend_r;
    if (in_tvalid && in_tready) begin
      pend_nxt = pend_nxt + 2'd1;
    end
    if (out_tvalid && out_tready) begin
      pend_nxt = pend_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `AST_IMP(a_empty_res, out_tvalid && out_tuser == pfq_pkg::ST_EMPTY, out_tdata[19] && out_tdata[18:0] == 19'd0, "empty result carries data or clear flag")
  `AST_IMP(a_served_ok, out_tvalid && out_tdata[18:16] != 3'd0, out_tuser == pfq_pkg::ST_OK, "served level with bad status")
  `AST_IMP(a_one_result, out_tvalid, pend_r == 2'd1, "result beat without exactly one pending operation")
  `AST_IMP(a_no_overlap, in_tvalid && in_tready, pend_r == 2'd0 || (out_tvalid && out_tready), "input beat taken while an operation is pending")

endmodule

bind five_level_priority_fifo_queue pfq_checker u_pfq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
